>>> design/bounded_queue_with_reverse_search_core_assert.svh
// Assertion macros for the bounded queue with reverse search.
// Included by the top level; depends on nothing else.
`ifndef BOUNDED_QUEUE_WITH_REVERSE_SEARCH_CORE_ASSERT_SVH
`define BOUNDED_QUEUE_WITH_REVERSE_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define BQRS_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("bqrs: same-cycle check violated");

// Next-cycle implication, disabled while in reset
`define BQRS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("bqrs: next-cycle check violated");

`endif

>>> design/bqrs_pkg.sv
// Shared types and codes for the bounded queue with reverse search.
// Used by bqrs_ctrl, bqrs_dp and the top level; no dependencies.
package bqrs_pkg;

    // Fixed field widths
    localparam int OP_W     = 3;
    localparam int WORD_W   = 32;
    localparam int ST_W     = 2;
    localparam int OCC_W    = 5;
    localparam int OUT_TD_W = 40;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ENQ   = 3'd0;
    localparam logic [OP_W-1:0] OP_DEQ   = 3'd1;
    localparam logic [OP_W-1:0] OP_SWAP  = 3'd2;
    localparam logic [OP_W-1:0] OP_REV   = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND  = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // Logical position that addresses the store
    typedef enum logic [1:0] {
        POS_ZERO,
        POS_LAST,
        POS_WALK,
        POS_COUNT
    } pos_sel_t;

    // Source of the store write data
    typedef enum logic [1:0] {
        WD_INPUT,
        WD_RDATA,
        WD_HOLD
    } wdat_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic      load;
        logic      rd_en;
        logic      wr_en;
        pos_sel_t  pos_sel;
        wdat_sel_t wdat_sel;
        logic      hold_en;
        logic      walk_inc;
        logic      srch_rd;
        logic      set_empty;
        logic      set_full;
        logic      enq_commit;
        logic      deq_commit;
        logic      rev_commit;
        logic      clr_commit;
        logic      out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic empty;
        logic full;
        logic lt2;
        logic walk_done;
        logic out_free;
    } sts_t;

endpackage

>>> design/bqrs_ctrl.sv
// Sequencing state machine of the bounded queue with reverse search.
// Depends on bqrs_pkg; drives bqrs_dp through cmd_t and reads sts_t.
module bqrs_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic [bqrs_pkg::OP_W-1:0]    opcode,
    output logic                         s_tready,
    output bqrs_pkg::cmd_t               cmd,
    input  bqrs_pkg::sts_t               sts
);
    import bqrs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ,
        S_DEQ,
        S_DEQ_WB,
        S_SWP_RA,
        S_SWP_RB,
        S_SWP_WA,
        S_SWP_WB,
        S_REV,
        S_SRCH,
        S_CLR,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    case (opcode)
                        OP_ENQ:   state_next = S_ENQ;
                        OP_DEQ:   state_next = S_DEQ;
                        OP_SWAP:  state_next = S_SWP_RA;
                        OP_REV:   state_next = S_REV;
                        OP_FIND:  state_next = S_SRCH;
                        OP_CLEAR: state_next = S_CLR;
                        default:  state_next = S_RESP;
                    endcase
                end
            end
            S_ENQ:
            begin
                if (sts.full)
                begin
                    cmd.set_full = 1'b1;
                end
                else
                begin
                    cmd.wr_en      = 1'b1;
                    cmd.pos_sel    = POS_COUNT;
                    cmd.wdat_sel   = WD_INPUT;
                    cmd.enq_commit = 1'b1;
                end
                state_next = S_RESP;
            end
            S_DEQ:
            begin
                if (sts.empty)
                begin
                    cmd.set_empty = 1'b1;
                    state_next    = S_RESP;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.pos_sel = POS_ZERO;
                    state_next  = S_DEQ_WB;
                end
            end
            S_DEQ_WB:
            begin
                cmd.deq_commit = 1'b1;
                state_next     = S_RESP;
            end
            S_SWP_RA:
            begin
                if (sts.lt2)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.pos_sel = POS_ZERO;
                    state_next  = S_SWP_RB;
                end
            end
            S_SWP_RB:
            begin
                // first word lands in the hold register while the last is read
                cmd.rd_en   = 1'b1;
                cmd.pos_sel = POS_LAST;
                cmd.hold_en = 1'b1;
                state_next  = S_SWP_WA;
            end
            S_SWP_WA:
            begin
                cmd.wr_en    = 1'b1;
                cmd.pos_sel  = POS_ZERO;
                cmd.wdat_sel = WD_RDATA;
                state_next   = S_SWP_WB;
            end
            S_SWP_WB:
            begin
                cmd.wr_en    = 1'b1;
                cmd.pos_sel  = POS_LAST;
                cmd.wdat_sel = WD_HOLD;
                state_next   = S_RESP;
            end
            S_REV:
            begin
                cmd.pos_sel    = POS_LAST;
                cmd.rev_commit = 1'b1;
                state_next     = S_RESP;
            end
            S_SRCH:
            begin
                // one read per cycle; each compare runs in the cycle after its read
                if (sts.walk_done)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.pos_sel  = POS_WALK;
                    cmd.srch_rd  = 1'b1;
                    cmd.walk_inc = 1'b1;
                end
            end
            S_CLR:
            begin
                cmd.clr_commit = 1'b1;
                state_next     = S_RESP;
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/bqrs_dp.sv
// Datapath of the bounded queue with reverse search: ring store, pointers,
// search comparator and output register. Depends on bqrs_pkg.
module bqrs_dp #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bqrs_pkg::cmd_t                   cmd,
    output bqrs_pkg::sts_t                   sts,
    input  logic [bqrs_pkg::WORD_W-1:0]      value_in,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [bqrs_pkg::OUT_TD_W-1:0]    m_tdata,
    output logic [bqrs_pkg::ST_W-1:0]        m_tuser
);
    import bqrs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (DATA_WIDTH > WORD_W) ? DATA_WIDTH : WORD_W;
    localparam int OW = (CW > OCC_W) ? CW : OCC_W;
    localparam int PAD_W = OUT_TD_W - WORD_W - 1 - OCC_W;
    localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // Ring store, no reset
    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [AW-1:0]         head_reg;
    logic [CW-1:0]         count_reg;
    logic                  rev_reg;
    logic [CW-1:0]         walk_reg;
    logic                  cmp_pend_reg;
    logic                  found_reg;
    logic [ST_W-1:0]       status_reg;
    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [DATA_WIDTH-1:0] hold_reg;
    logic [DATA_WIDTH-1:0] rdata_reg;
    logic [WORD_W-1:0]     res_value_reg;
    logic [OUT_TD_W-1:0]   out_data_reg;
    logic [ST_W-1:0]       out_user_reg;

    logic [CW-1:0]         pos;
    logic [AW-1:0]         addr;
    logic [AW-1:0]         head_adv;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  hit;
    logic [XW-1:0]         rd_wide;
    logic [OW-1:0]         cnt_wide;

    // Physical slot of a logical position, one compare and subtract
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic          rev,
                                              input logic [AW-1:0] p);
        logic [AW:0] s;
        if (rev)
            s = {1'b0, head} + DEPTH_S - {1'b0, p};
        else
            s = {1'b0, head} + {1'b0, p};
        if (s >= DEPTH_S)
            s = s - DEPTH_S;
        return s[AW-1:0];
    endfunction

    // Position select and address generation
    always_comb
    begin
        case (cmd.pos_sel)
            POS_ZERO:  pos = '0;
            POS_LAST:  pos = count_reg - CW'(1);
            POS_WALK:  pos = walk_reg;
            POS_COUNT: pos = count_reg;
            default:   pos = '0;
        endcase
    end

    assign addr     = slot_of(head_reg, rev_reg, pos[AW-1:0]);
    assign head_adv = slot_of(head_reg, rev_reg, AW'(1));

    // Write data select
    always_comb
    begin
        case (cmd.wdat_sel)
            WD_INPUT: wdata = val_reg;
            WD_RDATA: wdata = rdata_reg;
            WD_HOLD:  wdata = hold_reg;
            default:  wdata = val_reg;
        endcase
    end

    // Search compare and output word shaping
    assign hit      = cmp_pend_reg && (rdata_reg == val_reg);
    assign rd_wide  = XW'($signed(rdata_reg));
    assign cnt_wide = OW'(count_reg);

    // Store access: one port, read data registered
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    // Queue state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            walk_reg      <= '0;
            cmp_pend_reg  <= 1'b0;
            found_reg     <= 1'b0;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_pend_reg <= cmd.srch_rd;
            if (cmd.load)
            begin
                walk_reg   <= '0;
                found_reg  <= 1'b0;
                status_reg <= ST_OK;
            end
            else
            begin
                if (cmd.walk_inc)
                    walk_reg <= walk_reg + CW'(1);
                if (hit)
                    found_reg <= 1'b1;
                if (cmd.set_empty)
                    status_reg <= ST_EMPTY;
                if (cmd.set_full)
                    status_reg <= ST_FULL;
            end
            if (cmd.enq_commit)
                count_reg <= count_reg + CW'(1);
            if (cmd.deq_commit)
            begin
                head_reg  <= head_adv;
                count_reg <= count_reg - CW'(1);
            end
            // reverse: head moves to the former last entry
            if (cmd.rev_commit)
            begin
                if (count_reg != '0)
                    head_reg <= addr;
                rev_reg <= ~rev_reg;
            end
            if (cmd.clr_commit)
            begin
                count_reg <= '0;
                head_reg  <= '0;
                rev_reg   <= 1'b0;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            val_reg <= DATA_WIDTH'(value_in);
        if (cmd.hold_en)
            hold_reg <= rdata_reg;
        if (cmd.load)
            res_value_reg <= '0;
        else if (cmd.deq_commit)
            res_value_reg <= rd_wide[WORD_W-1:0];
        if (cmd.out_load)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, cnt_wide[OCC_W-1:0], found_reg, res_value_reg};
            out_user_reg <= status_reg;
        end
    end

    // Status to controller
    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg == DEPTH_C);
    assign sts.lt2       = (count_reg < CW'(2));
    assign sts.walk_done = (walk_reg == count_reg);
    assign sts.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

>>> design/bounded_queue_with_reverse_search_core.sv
// Bounded queue with reverse search: usage notes.
// Input channel s_*: one word per operation, opcode in s_tuser, operand in
// s_tdata. Output channel m_*: one result word per operation.
// Operations: enqueue, dequeue, swap first/last, reverse, contains, clear.
// Each operation runs through its own controller states, then the result
// stage: unused opcodes go straight there; enqueue, reverse, clear, refused
// operations and swap with fewer than two entries take an execute state;
// dequeue takes a read and a write-back; swap takes reads of the first and
// last entries, then writes of both; contains takes one read per entry and a
// final compare, as the search reads one entry per cycle through the single
// store port. One operation is in flight at a time and the next word is
// accepted in the cycle its result first shows. The result sits in an output
// register: the next operation is accepted while it waits, and a stalled
// receiver holds back only the next result. Reset empties the queue, sets
// forward order and drops any pending result; store contents are not cleared
// and need no clearing pass. Depends on bqrs_pkg, bqrs_ctrl, bqrs_dp and the assertion header.
`include "bounded_queue_with_reverse_search_core_assert.svh"

module bounded_queue_with_reverse_search_core #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bqrs_pkg::WORD_W-1:0]      s_tdata,  // [31:0] value_in
    input  logic [bqrs_pkg::OP_W-1:0]        s_tuser,  // [2:0] opcode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] value_out, [32] found, [37:33] occupancy, [39:38] zero
    output logic [bqrs_pkg::OUT_TD_W-1:0]    m_tdata,
    output logic [bqrs_pkg::ST_W-1:0]        m_tuser   // [1:0] status
);
    import bqrs_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer
    bqrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .opcode   (s_tuser),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Store, pointers and output register
    bqrs_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .value_in (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Checks
    `BQRS_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `BQRS_ASSERT_NOW(a_load_when_free, clk, rst_n, cmd.out_load, sts.out_free)
    `BQRS_ASSERT_NOW(a_port_exclusive, clk, rst_n, cmd.rd_en, !cmd.wr_en)

endmodule

>>> dv/queue_result_checker.sv
// Result checker for the bounded queue with reverse search: watches both
// stream channels, predicts each result word and compares it field by field.
// Depends on bqrs_pkg for widths, operation and status codes.
module queue_result_checker #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [bqrs_pkg::WORD_W-1:0]   s_tdata,   // [31:0] value_in
    input  logic [bqrs_pkg::OP_W-1:0]     s_tuser,   // [2:0] opcode
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] value_out, [32] found, [37:33] occupancy, [39:38] zero
    input  logic [bqrs_pkg::OUT_TD_W-1:0] m_tdata,
    input  logic [bqrs_pkg::ST_W-1:0]     m_tuser,   // [1:0] status
    output int                            mismatches,
    output int                            outstanding,
    output int                            results_seen,
    output int                            refused_seen,
    output int                            empty_seen,
    output int                            hits_seen
);
    import bqrs_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              found;
        logic [ST_W-1:0]   status;
        logic [OCC_W-1:0]  occupancy;
    } queue_result_t;

    // Shadow ring buffer
    logic [WORD_W-1:0] slot_word [DEPTH];
    int unsigned       head_slot;
    int unsigned       held_count;
    bit                reversed;

    queue_result_t     expected_results [$];
    int                reports_printed;

    // Physical slot of logical position pos, honouring the reading direction
    function automatic int unsigned slot_at(input int unsigned pos);
        if (reversed)
            return (head_slot + DEPTH - (pos % DEPTH)) % DEPTH;
        return (head_slot + pos) % DEPTH;
    endfunction

    // Apply one operation to the shadow queue and return the result word
    function queue_result_t predict_queue_op(input logic [OP_W-1:0] op,
                                             input logic [WORD_W-1:0] operand);
        queue_result_t     r;
        int unsigned       a;
        int unsigned       b;
        logic [WORD_W-1:0] t;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_ENQ:
            begin
                if (held_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    slot_word[slot_at(held_count)] = operand;
                    held_count++;
                end
            end
            OP_DEQ:
            begin
                if (held_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.value = slot_word[head_slot];
                    head_slot = slot_at(1);
                    held_count--;
                end
            end
            OP_SWAP:
            begin
                // fewer than two entries: nothing to exchange
                if (held_count >= 2)
                begin
                    a = slot_at(0);
                    b = slot_at(held_count - 1);
                    t = slot_word[a];
                    slot_word[a] = slot_word[b];
                    slot_word[b] = t;
                end
            end
            OP_REV:
            begin
                if (held_count > 0)
                    head_slot = slot_at(held_count - 1);
                reversed = !reversed;
            end
            OP_FIND:
            begin
                for (int i = 0; i < held_count; i++)
                    if (slot_word[slot_at(i)] == operand)
                        r.found = 1'b1;
            end
            OP_CLEAR:
            begin
                held_count = 0;
                head_slot = 0;
                reversed = 1'b0;
            end
            default: ;  // spare opcodes do nothing
        endcase
        r.occupancy = held_count[OCC_W-1:0];
        return r;
    endfunction

    task automatic report_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
        mismatches++;
        if (reports_printed < 30)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
            reports_printed++;
        end
    endtask

    // Predict on input acceptance, compare on output acceptance
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        queue_result_t want;
        if (!rst_n)
        begin
            head_slot = 0;
            held_count = 0;
            reversed = 1'b0;
            expected_results.delete();
            mismatches = 0;
            outstanding = 0;
            results_seen = 0;
            refused_seen = 0;
            empty_seen = 0;
            hits_seen = 0;
            reports_printed = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result word, expected none, actual 0x%0h/%0d",
                             $time, m_tdata, m_tuser);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.status == ST_FULL)
                        refused_seen++;
                    if (want.status == ST_EMPTY)
                        empty_seen++;
                    if (want.found)
                        hits_seen++;
                    if (m_tdata[31:0] !== want.value)
                        report_field("value_out", 64'(want.value), 64'(m_tdata[31:0]));
                    if (m_tdata[32] !== want.found)
                        report_field("found", 64'(want.found), 64'(m_tdata[32]));
                    if (m_tdata[37:33] !== want.occupancy)
                        report_field("occupancy", 64'(want.occupancy),
                                     64'(m_tdata[37:33]));
                    if (m_tdata[39:38] !== 2'b00)
                        report_field("pad", 64'(2'b00), 64'(m_tdata[39:38]));
                    if (m_tuser !== want.status)
                        report_field("status", 64'(want.status), 64'(m_tuser));
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_queue_op(s_tuser, s_tdata));
            outstanding = expected_results.size();
        end
    end

endmodule

>>> dv/testbench.sv
// Top of the bounded queue testbench: clock, reset, stimulus and verdict.
// Depends on bqrs_pkg, the block bounded_queue_with_reverse_search_core and
// queue_result_checker, which does all prediction and comparison.
module testbench;
    import bqrs_pkg::*;

    localparam int DEPTH       = 16;
    localparam int PHASES      = 20;
    localparam int PHASE_WORDS = 100;
    localparam int HOLD_CYCLES = 400;

    // Opcodes the block treats as no operation
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [WORD_W-1:0]   s_tdata;
    logic [OP_W-1:0]     s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_TD_W-1:0] m_tdata;
    logic [ST_W-1:0]     m_tuser;

    int mismatches;
    int outstanding;
    int results_seen;
    int refused_seen;
    int empty_seen;
    int hits_seen;

    logic tx_idle_on  = 1'b0;
    logic rx_idle_on  = 1'b0;
    logic rx_hold_req = 1'b0;

    int                op_sent [8] = '{default: 0};
    logic [WORD_W-1:0] recent_words [16];
    int                enq_total = 0;

    always #5 clk = ~clk;

    bounded_queue_with_reverse_search_core #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (32)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    queue_result_checker #(
        .DEPTH (DEPTH)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .refused_seen (refused_seen),
        .empty_seen   (empty_seen),
        .hits_seen    (hits_seen)
    );

    // Mostly short gaps, now and then a long one
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Operand: recently queued words so searches hit, extremes, or anything
    function automatic logic [WORD_W-1:0] pick_word();
        int r;
        int span;
        r = $urandom_range(0, 99);
        span = (enq_total < 16) ? enq_total : 16;
        if (r < 35 && span > 0)
            return recent_words[$urandom_range(0, span - 1)];
        if (r < 45)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    // Operation mix; enqueue and dequeue shares steer the fill level
    function automatic logic [OP_W-1:0] pick_op(input int enq_pct, input int deq_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < enq_pct)
            return OP_ENQ;
        if (r < enq_pct + deq_pct)
            return OP_DEQ;
        r = $urandom_range(0, 99);
        if (r < 35)
            return OP_FIND;
        if (r < 60)
            return OP_SWAP;
        if (r < 86)
            return OP_REV;
        if (r < 94)
            return OP_CLEAR;
        return (r < 97) ? OP_SPARE_A : OP_SPARE_B;
    endfunction

    task automatic idle_input(input int cycles);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Offer one word and hold it until the block takes it
    task automatic push_word(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] operand);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= operand;
        do
            @(posedge clk);
        while (!s_tready);
        op_sent[op]++;
        if (op == OP_ENQ)
        begin
            recent_words[enq_total % 16] = operand;
            enq_total++;
        end
        if (tx_idle_on && $urandom_range(0, 3) == 0)
            idle_input(gap_length());
    endtask

    // Sender pause until every predicted result has come back
    task automatic drain_results();
        idle_input(1);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin : receiver
        int stall;
        stall = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                rx_hold_req = 1'b0;
            end
            else if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 2) == 0)
                    stall = gap_length();
            end
        end
    end

    initial
    begin : stimulus
        int enq_pct;
        int deq_pct;
        int waited;
        int fails;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_ENQ;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty cases, extremes, each operation, full queue
        push_word(OP_DEQ, 32'h0000_0000);       // dequeue on empty
        push_word(OP_REV, 32'h0000_0000);       // reverse on empty
        push_word(OP_ENQ, 32'h7FFF_FFFF);
        push_word(OP_SWAP, 32'h0000_0000);      // swap with a single entry
        push_word(OP_ENQ, 32'h8000_0000);
        push_word(OP_ENQ, 32'h0000_0000);
        push_word(OP_ENQ, 32'hFFFF_FFFF);
        push_word(OP_ENQ, 32'h0000_0001);
        push_word(OP_SWAP, 32'h0000_0000);
        push_word(OP_REV, 32'h0000_0000);
        push_word(OP_FIND, 32'h8000_0000);
        push_word(OP_FIND, 32'h0000_3039);
        push_word(OP_DEQ, 32'h0000_0000);
        push_word(OP_SPARE_A, 32'hFFFF_FFFF);
        repeat (12) push_word(OP_ENQ, $urandom());
        push_word(OP_ENQ, 32'h5A5A_5A5A);       // refused, queue full
        push_word(OP_FIND, 32'h0000_0001);
        push_word(OP_CLEAR, 32'h0000_0000);
        drain_results();

        // Random phases: fill, drain and balanced mixes under varied idling
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 3)
                0:
                begin
                    enq_pct = 60;
                    deq_pct = 10;
                end
                1:
                begin
                    enq_pct = 15;
                    deq_pct = 50;
                end
                default:
                begin
                    enq_pct = 35;
                    deq_pct = 25;
                end
            endcase
            tx_idle_on = (phase % 4 == 1) || (phase % 4 == 3);
            rx_idle_on = (phase % 4 >= 2);
            // long receiver hold-off while the sender keeps offering
            if (phase == 6)
                rx_hold_req = 1'b1;
            repeat (PHASE_WORDS) push_word(pick_op(enq_pct, deq_pct), pick_word());
            if (phase % 3 == 2)
                drain_results();
        end

        // Wind down: wait for the last results, then a few quiet cycles
        idle_input(1);
        waited = 0;
        while (outstanding != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (40) @(negedge clk);
        fails = mismatches;
        if (outstanding != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, outstanding);
            fails++;
        end
        $display("Sent enq %0d, deq %0d, swap %0d, reverse %0d, contains %0d, clear %0d, spare %0d",
                 op_sent[OP_ENQ], op_sent[OP_DEQ], op_sent[OP_SWAP], op_sent[OP_REV],
                 op_sent[OP_FIND], op_sent[OP_CLEAR], op_sent[OP_SPARE_A] + op_sent[OP_SPARE_B]);
        $display("Checked %0d results: %0d refused full, %0d dequeue on empty, %0d search hits",
                 results_seen, refused_seen, empty_seen, hits_seen);
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #15_000_000;
        $display("%0t: run timed out", $time);
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/bqrs_pkg.sv
design/bqrs_ctrl.sv
design/bqrs_dp.sv
design/bounded_queue_with_reverse_search_core.sv
dv/queue_result_checker.sv
dv/testbench.sv
